// ----- design/vssa_pkg.sv -----
// Package for the variable size stack allocator: request and result word types,
// command codes and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vssa_pkg;

    // Default sizing of the byte pool
    localparam int POOL_BYTES_DEF    = 4096;
    localparam int TRAILER_BYTES_DEF = 4;

    // Fixed field widths
    localparam int CMD_W      = 3;
    localparam int SIZE_W     = 12;
    localparam int HANDLE_W   = 12;
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int USED_OUT_W = 13;
    localparam int CHUNK_W    = 13;

    // Item count at which allocate is refused
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAN = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TOP   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PREV  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ITEM  = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [SIZE_W-1:0]  size_bytes;
        logic [HANDLE_W-1:0] handle_in;
        logic [INDEX_W-1:0] item_index;
    } request_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]   handle_out;
        logic                  ok;
        logic [COUNT_W-1:0]    count;
        logic [USED_OUT_W-1:0] used;
    } result_t;

endpackage

`default_nettype wire

// ----- design/variable_size_stack_allocator_core.sv -----
// Stack allocator over a byte pool: counters in flops, chunk trailers in one
// synchronous memory with a registered read. Depends on vssa_pkg.
// Allocate, pop, clean, top and unknown codes give their result from the idle
// decode; previous-of first reads one trailer; item-by-number walks the trailers
// down from the top, one trailer read per cycle on the single memory port.
// Allocate, clean and top leave the core idle; pop and previous-of hold busy
// for one trailer read each. Results cannot be stalled by the receiver.
// Reset clears used bytes, item count and last chunk; trailers are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module variable_size_stack_allocator_core
    import vssa_pkg::*;
#(
    parameter int POOL_BYTES    = POOL_BYTES_DEF,
    parameter int TRAILER_BYTES = TRAILER_BYTES_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire request_t request,
    output logic          busy,
    output logic          done,
    output result_t       result
);

    localparam int STORE_WORDS = POOL_BYTES / 4;
    localparam int ADDR_W      = $clog2(STORE_WORDS);
    localparam int USED_W      = $clog2(POOL_BYTES + 1);
    localparam int W           = (USED_W > CHUNK_W) ? USED_W : CHUNK_W;
    localparam int TW          = W + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_PREV = 4'b0100,
        S_WALK = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [USED_W-1:0]    used_reg, used_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [CHUNK_W-1:0]   last_reg, last_next;
    logic [W-1:0]         p_reg, p_next;
    logic [COUNT_W-1:0]   i_reg, i_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    result_t              res_reg, res_next;
    logic                 done_reg, done_next;

    // Trailer memory
    logic [CHUNK_W-1:0]   trailer_mem [STORE_WORDS];
    logic [CHUNK_W-1:0]   rd_data_reg;
    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [CHUNK_W-1:0]   wr_data;

    // Datapath helpers
    logic [W-1:0]         used_w, last_w, len_w, pop_used_w, walk_p_w;
    logic [CHUNK_W-1:0]   chunk;
    logic [TW-1:0]        req, pos_e;
    logic [COUNT_W-1:0]   walk_i;
    logic                 accept;

    // True when a chunk end offset maps onto a trailer word in the store
    function automatic logic idx_ok(input logic [TW-1:0] e);
        logic [TW-1:0] wd;
        wd = (e - TW'(TRAILER_BYTES)) >> 2;
        return (e >= TW'(TRAILER_BYTES)) && (wd < TW'(STORE_WORDS));
    endfunction

    function automatic logic [ADDR_W-1:0] idx_addr(input logic [TW-1:0] e);
        logic [TW-1:0] wd;
        wd = (e - TW'(TRAILER_BYTES)) >> 2;
        return wd[ADDR_W-1:0];
    endfunction

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // Shared arithmetic
    assign used_w     = W'(used_reg);
    assign last_w     = W'(last_reg);
    assign len_w      = W'(rd_data_reg);
    assign chunk      = ((CHUNK_W'(request.size_bytes) + CHUNK_W'(3)) & ~CHUNK_W'(3))
                        + CHUNK_W'(TRAILER_BYTES);
    assign req        = TW'(used_w) + TW'(chunk);
    assign pos_e      = TW'(request.handle_in);
    assign pop_used_w = (last_w > used_w) ? '0 : (used_w - last_w);
    assign walk_p_w   = p_reg - len_w;
    assign walk_i     = i_reg - COUNT_W'(1);

    // Command decode and trailer walk
    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        count_next = count_reg;
        last_next  = last_reg;
        p_next     = p_reg;
        i_next     = i_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        wr_addr    = idx_addr(req);
        wr_data    = chunk;
        rd_addr    = idx_addr(TW'(pop_used_w));

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next           = 1'b1;
                    res_next.handle_out = '0;
                    res_next.ok         = 1'b0;
                    unique case (request.command)
                        CMD_ALLOC:
                        begin
                            if ((req <= TW'(POOL_BYTES)) && (count_reg < COUNT_MAX)
                                && idx_ok(req))
                            begin
                                mem_we              = 1'b1;
                                res_next.handle_out = HANDLE_W'(used_w);
                                res_next.ok         = 1'b1;
                                last_next           = chunk;
                                used_next           = USED_W'(req);
                                count_next          = count_reg + COUNT_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (used_reg != '0)
                            begin
                                used_next           = USED_W'(pop_used_w);
                                count_next          = (count_reg != '0) ?
                                                      count_reg - COUNT_W'(1) : count_reg;
                                res_next.handle_out = HANDLE_W'(pop_used_w);
                                res_next.ok         = 1'b1;
                                if ((pop_used_w == '0) || !idx_ok(TW'(pop_used_w)))
                                begin
                                    last_next = '0;
                                end
                                else
                                begin
                                    mem_re     = 1'b1;
                                    state_next = S_LOAD;
                                end
                            end
                        end
                        CMD_CLEAN:
                        begin
                            used_next   = '0;
                            count_next  = '0;
                            last_next   = '0;
                            res_next.ok = 1'b1;
                        end
                        CMD_TOP:
                        begin
                            if ((used_reg != '0) && (last_w <= used_w))
                            begin
                                res_next.handle_out = HANDLE_W'(used_w - last_w);
                                res_next.ok         = 1'b1;
                            end
                        end
                        CMD_PREV:
                        begin
                            if ((used_reg != '0) && (request.handle_in != '0) && idx_ok(pos_e))
                            begin
                                rd_addr    = idx_addr(pos_e);
                                mem_re     = 1'b1;
                                p_next     = W'(request.handle_in);
                                done_next  = 1'b0;
                                state_next = S_PREV;
                            end
                        end
                        CMD_ITEM:
                        begin
                            if ((used_reg != '0)
                                && (COUNT_W'(request.item_index) < count_reg)
                                && idx_ok(TW'(used_w)))
                            begin
                                rd_addr    = idx_addr(TW'(used_w));
                                mem_re     = 1'b1;
                                p_next     = used_w;
                                i_next     = count_reg;
                                idx_next   = request.item_index;
                                done_next  = 1'b0;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    res_next.count = count_next;
                    res_next.used  = USED_OUT_W'(W'(used_next));
                end
            end
            S_LOAD:
            begin
                // Take the new top chunk length from its trailer
                last_next  = rd_data_reg;
                state_next = S_IDLE;
            end
            S_PREV:
            begin
                done_next           = 1'b1;
                res_next.count      = count_reg;
                res_next.used       = USED_OUT_W'(used_w);
                res_next.handle_out = '0;
                res_next.ok         = 1'b0;
                if (len_w <= p_reg)
                begin
                    res_next.handle_out = HANDLE_W'(walk_p_w);
                    res_next.ok         = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                // Step one trailer down; issue the next read from the new end
                res_next.count      = count_reg;
                res_next.used       = USED_OUT_W'(used_w);
                res_next.handle_out = '0;
                res_next.ok         = 1'b0;
                p_next              = walk_p_w;
                i_next              = walk_i;
                rd_addr             = idx_addr(TW'(walk_p_w));
                if (len_w > p_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (walk_i == COUNT_W'(idx_reg))
                begin
                    done_next           = 1'b1;
                    res_next.handle_out = HANDLE_W'(walk_p_w);
                    res_next.ok         = 1'b1;
                    state_next          = S_IDLE;
                end
                else if (!idx_ok(TW'(walk_p_w)))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and bookkeeping registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            count_reg <= '0;
            last_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            done_reg  <= done_next;
        end
    end

    // Walk pointers and result word
    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        i_reg   <= i_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

    // Trailer memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            trailer_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= trailer_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/vssa_checker.sv -----
// Port-level checks for the stack allocator core, bound to the core module.
// Depends on vssa_pkg and variable_size_stack_allocator_core.
`timescale 1ns / 1ps
`default_nettype none

module vssa_checker
    import vssa_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire request_t request,
    input wire logic     busy,
    input wire logic     done,
    input wire result_t  result
);

    // A result word only follows an accepted command or work in progress
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) || $past(busy)))
        else $error("result word without a command");

    // A failed command reports a zero handle
    a_fail_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.ok) |-> (result.handle_out == '0))
        else $error("failed result carries a handle");

    // Busy only rises on an accepted command
    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

    // A command that leaves busy set ends before the next command is taken
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(busy) && !$past(done)) |-> (done || $past(request.command) != CMD_ALLOC))
        else $error("busy ended without a result");

endmodule

bind variable_size_stack_allocator_core vssa_checker u_vssa_checker (.*);

`default_nettype wire
